// ===== sv/e2b_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package e2b_pkg;

    // Fixed formats of the stream fields.
    localparam int ANGLE_W         = 18;
    localparam int COMP_W          = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int TRIG_STAGES     = 16;
    localparam int MAX_STAGES      = 32;

    // Angle reduction, all in 2^-ANGLE_FRAC_BITS degree units.
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int EIGHTH_TURN  = 45 << ANGLE_FRAC_BITS;
    localparam int MOD_W        = 17;
    localparam int RABS_W       = 14;

    // |r| = 45*a + b; a is found by a reciprocal multiply.
    localparam int DIV45        = 45;
    localparam int RECIP45      = 23302;
    localparam int RECIP45_SH   = 20;
    localparam int A45_W        = 9;
    localparam int B45_W        = 6;
    localparam int HALF_DEN     = (180 << ANGLE_FRAC_BITS) / 2;

    // Word widths: CORDIC values in Q.40, sine and cosine in Q.30, products in Q.60.
    localparam int XY_W   = 43;
    localparam int Z_W    = 42;
    localparam int ZPROD_W = 52;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 64;

    localparam logic [63:0] PI4_Q62  = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q40   = (PI4_Q62 + (64'd1 << 19)) >> 20;
    localparam logic [63:0] GAIN_Q40 = 64'h26DD3B6A << 10;

    // Component indices of the result.
    localparam int FWD_X = 0;
    localparam int FWD_Y = 1;
    localparam int FWD_Z = 2;
    localparam int RGT_X = 3;
    localparam int RGT_Y = 4;
    localparam int RGT_Z = 5;
    localparam int UP_X  = 6;
    localparam int UP_Y  = 7;
    localparam int UP_Z  = 8;
    localparam int NUM_COMP = 9;

    typedef struct packed {
        logic                  neg;
        logic [1:0]            quad;
        logic signed [Z_W-1:0] z;
    } angle_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    typedef logic [63:0] atan_tab_t [MAX_STAGES];
    typedef logic [63:0] btab_t [DIV45];

    // Bit-serial long division, evaluated only while building tables.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], n[k]};
            if (r >= d)
            begin
                r    = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q.40: series summed in Q.62 then rounded.
    function automatic atan_tab_t build_atan();
        atan_tab_t   t;
        logic [63:0] sum;
        logic [63:0] term;
        int          sh;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (i == 0)
            begin
                t[i] = (PI4_Q62 + (64'd1 << 21)) >> 22;
            end
            else
            begin
                sum = '0;
                for (int k = 0; k < MAX_STAGES; k++)
                begin
                    sh = i * (2 * k + 1);
                    if (sh <= 62)
                    begin
                        term = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
                        if (k % 2 == 1)
                            sum = sum - term;
                        else
                            sum = sum + term;
                    end
                end
                t[i] = (sum + (64'd1 << 21)) >> 22;
            end
        end
        return t;
    endfunction

    // floor((b*pi + half denominator) / 45) for the remainder b of |r| / 45.
    function automatic btab_t build_btab();
        btab_t t;
        for (int b = 0; b < DIV45; b++)
        begin
            t[b] = (64'(b) * PI_Q40 + 64'(HALF_DEN)) / DIV45;
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_Q40 = build_atan();
    localparam btab_t     B_TAB    = build_btab();

    // Round a Q.60 sum to the output format and clamp to +/- one.
    function automatic logic [COMP_W-1:0] emit(input logic signed [PROD_W-1:0] v60);
        logic signed [PROD_W-1:0] v;
        v = (v60 + (64'sd1 <<< (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
        if (v > (64'sd1 <<< OUT_FRAC_BITS))
            v = 64'sd1 <<< OUT_FRAC_BITS;
        else if (v < -(64'sd1 <<< OUT_FRAC_BITS))
            v = -(64'sd1 <<< OUT_FRAC_BITS);
        return v[COMP_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/e2b_angle_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four stages: wrap into one turn, split off the quadrant, divide |r| by 45,
// scale to radians in Q.40.
module e2b_angle_reduce
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic signed [e2b_pkg::ANGLE_W-1:0] angle,
    output logic                                  out_valid,
    output e2b_pkg::angle_t                       out_angle
);

    logic [3:0] valid_reg;

    // Stage 1: wrap into [0, full turn).
    logic signed [19:0]               a_ext;
    logic signed [19:0]               m_next;
    logic [e2b_pkg::MOD_W-1:0]        m_reg;

    always_comb
    begin
        a_ext = 20'(angle);
        if (a_ext < -20'sd92160)
            m_next = a_ext + 20'(2 * e2b_pkg::FULL_TURN);
        else if (a_ext < 20'sd0)
            m_next = a_ext + 20'(e2b_pkg::FULL_TURN);
        else if (a_ext >= 20'(e2b_pkg::FULL_TURN))
            m_next = a_ext - 20'(e2b_pkg::FULL_TURN);
        else
            m_next = a_ext;
    end

    // Stage 2: nearest quadrant and signed remainder.
    logic [2:0]                       q_cnt;
    logic [e2b_pkg::MOD_W-1:0]        q_sub;
    logic signed [e2b_pkg::MOD_W:0]   r_val;
    logic signed [e2b_pkg::MOD_W:0]   r_abs;
    logic [e2b_pkg::RABS_W-1:0]       rabs_reg;
    logic                             neg2_reg;
    logic [1:0]                       quad2_reg;

    always_comb
    begin
        q_cnt = 3'(m_reg >= 17'(e2b_pkg::EIGHTH_TURN))
              + 3'(m_reg >= 17'(e2b_pkg::EIGHTH_TURN + e2b_pkg::QUARTER_TURN))
              + 3'(m_reg >= 17'(e2b_pkg::EIGHTH_TURN + 2 * e2b_pkg::QUARTER_TURN))
              + 3'(m_reg >= 17'(e2b_pkg::EIGHTH_TURN + 3 * e2b_pkg::QUARTER_TURN));
        case (q_cnt)
            3'd0:    q_sub = '0;
            3'd1:    q_sub = 17'(e2b_pkg::QUARTER_TURN);
            3'd2:    q_sub = 17'(2 * e2b_pkg::QUARTER_TURN);
            3'd3:    q_sub = 17'(3 * e2b_pkg::QUARTER_TURN);
            default: q_sub = 17'(4 * e2b_pkg::QUARTER_TURN);
        endcase
        r_val = $signed({1'b0, m_reg}) - $signed({1'b0, q_sub});
        r_abs = (r_val < 0) ? -r_val : r_val;
    end

    // Stage 3: |r| = 45*a + b.
    logic [28:0]                      a_prod;
    logic [e2b_pkg::A45_W-1:0]        a_next;
    logic [e2b_pkg::RABS_W-1:0]       b_full;
    logic [e2b_pkg::A45_W-1:0]        a_reg;
    logic [e2b_pkg::B45_W-1:0]        b_reg;
    logic                             neg3_reg;
    logic [1:0]                       quad3_reg;

    always_comb
    begin
        a_prod = 29'(rabs_reg) * 29'(e2b_pkg::RECIP45);
        a_next = a_prod[e2b_pkg::RECIP45_SH +: e2b_pkg::A45_W];
        b_full = rabs_reg - 14'(a_next * 14'(e2b_pkg::DIV45));
    end

    // Stage 4: radians in Q.40, rounded to nearest.
    logic [e2b_pkg::ZPROD_W-1:0]      n_val;
    e2b_pkg::angle_t                  ang_reg;

    assign n_val = 52'(a_reg) * 52'(e2b_pkg::PI_Q40[41:0])
                 + 52'(e2b_pkg::B_TAB[b_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg         <= m_next[e2b_pkg::MOD_W-1:0];
            rabs_reg      <= r_abs[e2b_pkg::RABS_W-1:0];
            neg2_reg      <= r_val < 0;
            quad2_reg     <= q_cnt[1:0];
            a_reg         <= a_next;
            b_reg         <= b_full[e2b_pkg::B45_W-1:0];
            neg3_reg      <= neg2_reg;
            quad3_reg     <= quad2_reg;
            ang_reg.neg   <= neg3_reg;
            ang_reg.quad  <= quad3_reg;
            ang_reg.z     <= $signed(n_val[e2b_pkg::ZPROD_W-1:10]);
        end
    end

    assign out_valid = valid_reg[3];
    assign out_angle = ang_reg;

endmodule
`default_nettype wire

// ===== sv/e2b_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One register stage per CORDIC rotation, then a stage that rounds to Q.30
// and restores sign and quadrant.
module e2b_cordic
#(
    parameter int TRIG_STAGES = e2b_pkg::TRIG_STAGES
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire e2b_pkg::angle_t in_angle,
    output logic                 out_valid,
    output e2b_pkg::trig_t       out_trig
);

    localparam int LAST = TRIG_STAGES - 1;

    logic signed [e2b_pkg::XY_W-1:0] x_reg [TRIG_STAGES];
    logic signed [e2b_pkg::XY_W-1:0] y_reg [TRIG_STAGES];
    logic signed [e2b_pkg::Z_W-1:0]  z_reg [TRIG_STAGES];
    logic                            neg_reg [TRIG_STAGES];
    logic [1:0]                      quad_reg [TRIG_STAGES];
    logic [TRIG_STAGES-1:0]          valid_reg;

    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_stage
        logic signed [e2b_pkg::XY_W-1:0] x_in;
        logic signed [e2b_pkg::XY_W-1:0] y_in;
        logic signed [e2b_pkg::Z_W-1:0]  z_in;
        logic                            neg_in;
        logic [1:0]                      quad_in;
        logic                            v_in;
        logic signed [e2b_pkg::Z_W-1:0]  at;
        logic signed [e2b_pkg::XY_W-1:0] x_next;
        logic signed [e2b_pkg::XY_W-1:0] y_next;
        logic signed [e2b_pkg::Z_W-1:0]  z_next;

        if (i == 0)
        begin : g_first
            assign x_in    = $signed(e2b_pkg::GAIN_Q40[e2b_pkg::XY_W-1:0]);
            assign y_in    = '0;
            assign z_in    = in_angle.z;
            assign neg_in  = in_angle.neg;
            assign quad_in = in_angle.quad;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign quad_in = quad_reg[i-1];
            assign v_in    = valid_reg[i-1];
        end

        assign at = $signed(e2b_pkg::ATAN_Q40[i][e2b_pkg::Z_W-1:0]);

        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - at;
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                neg_reg[i]  <= neg_in;
                quad_reg[i] <= quad_in;
            end
        end
    end

    logic signed [e2b_pkg::XY_W-1:0]   c_rnd;
    logic signed [e2b_pkg::XY_W-1:0]   s_rnd;
    logic signed [e2b_pkg::TRIG_W-1:0] c_val;
    logic signed [e2b_pkg::TRIG_W-1:0] s_val;
    e2b_pkg::trig_t                    trig_next;
    e2b_pkg::trig_t                    trig_reg;
    logic                              tv_reg;

    always_comb
    begin
        c_rnd = (x_reg[LAST] + 43'sd512) >>> 10;
        s_rnd = (y_reg[LAST] + 43'sd512) >>> 10;
        c_val = c_rnd[e2b_pkg::TRIG_W-1:0];
        s_val = neg_reg[LAST] ? -s_rnd[e2b_pkg::TRIG_W-1:0] : s_rnd[e2b_pkg::TRIG_W-1:0];
        case (quad_reg[LAST])
            2'd0:    begin trig_next.s = s_val;  trig_next.c = c_val;  end
            2'd1:    begin trig_next.s = c_val;  trig_next.c = -s_val; end
            2'd2:    begin trig_next.s = -s_val; trig_next.c = -c_val; end
            default: begin trig_next.s = -c_val; trig_next.c = s_val;  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else if (en)
            tv_reg <= valid_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            trig_reg <= trig_next;
    end

    assign out_valid = tv_reg;
    assign out_trig  = trig_reg;

endmodule
`default_nettype wire

// ===== sv/e2b_basis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Five stages: pair products, rounding of the triple-product prefixes,
// triple products, sums, rounding and clamping.
module e2b_basis
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire e2b_pkg::trig_t pitch,
    input  wire e2b_pkg::trig_t yaw,
    input  wire e2b_pkg::trig_t roll,
    output logic                out_valid,
    output logic [e2b_pkg::COMP_W-1:0] comp [e2b_pkg::NUM_COMP]
);

    typedef logic signed [e2b_pkg::PROD_W-1:0] prod_t;
    typedef logic signed [e2b_pkg::TRIG_W-1:0] q30_t;

    logic [4:0] valid_reg;

    // Stage 1 products.
    prod_t srsp1_reg, crsp1_reg, cpcy1_reg, cpsy1_reg, srcp1_reg, crcp1_reg;
    prod_t crsy1_reg, crcy1_reg, srsy1_reg, srcy1_reg;
    q30_t  sp1_reg, sy1_reg, cy1_reg;

    // Stage 2: rounded prefixes.
    prod_t srsp_rnd, crsp_rnd;
    q30_t  srsp2_reg, crsp2_reg, sp2_reg, sy2_reg, cy2_reg;
    prod_t cpcy2_reg, cpsy2_reg, srcp2_reg, crcp2_reg;
    prod_t crsy2_reg, crcy2_reg, srsy2_reg, srcy2_reg;

    // Stage 3: triple products.
    prod_t srspcy3_reg, srspsy3_reg, crspcy3_reg, crspsy3_reg;
    prod_t cpcy3_reg, cpsy3_reg, srcp3_reg, crcp3_reg;
    prod_t crsy3_reg, crcy3_reg, srsy3_reg, srcy3_reg;
    q30_t  sp3_reg;

    // Stage 4: sums.
    prod_t sum_reg [e2b_pkg::NUM_COMP];
    prod_t sum_next [e2b_pkg::NUM_COMP];

    // Stage 5: output.
    logic [e2b_pkg::COMP_W-1:0] comp_reg [e2b_pkg::NUM_COMP];

    always_comb
    begin
        srsp_rnd = (srsp1_reg + 64'sd536870912) >>> 30;
        crsp_rnd = (crsp1_reg + 64'sd536870912) >>> 30;
    end

    always_comb
    begin
        sum_next[e2b_pkg::FWD_X] = cpcy3_reg;
        sum_next[e2b_pkg::FWD_Y] = cpsy3_reg;
        sum_next[e2b_pkg::FWD_Z] = -(prod_t'(sp3_reg) <<< 30);
        sum_next[e2b_pkg::RGT_X] = crsy3_reg - srspcy3_reg;
        sum_next[e2b_pkg::RGT_Y] = -srspsy3_reg - crcy3_reg;
        sum_next[e2b_pkg::RGT_Z] = -srcp3_reg;
        sum_next[e2b_pkg::UP_X]  = crspcy3_reg + srsy3_reg;
        sum_next[e2b_pkg::UP_Y]  = crspsy3_reg - srcy3_reg;
        sum_next[e2b_pkg::UP_Z]  = crcp3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp1_reg <= roll.s * pitch.s;
            crsp1_reg <= roll.c * pitch.s;
            cpcy1_reg <= pitch.c * yaw.c;
            cpsy1_reg <= pitch.c * yaw.s;
            srcp1_reg <= roll.s * pitch.c;
            crcp1_reg <= roll.c * pitch.c;
            crsy1_reg <= roll.c * yaw.s;
            crcy1_reg <= roll.c * yaw.c;
            srsy1_reg <= roll.s * yaw.s;
            srcy1_reg <= roll.s * yaw.c;
            sp1_reg   <= pitch.s;
            sy1_reg   <= yaw.s;
            cy1_reg   <= yaw.c;

            srsp2_reg <= srsp_rnd[e2b_pkg::TRIG_W-1:0];
            crsp2_reg <= crsp_rnd[e2b_pkg::TRIG_W-1:0];
            sp2_reg   <= sp1_reg;
            sy2_reg   <= sy1_reg;
            cy2_reg   <= cy1_reg;
            cpcy2_reg <= cpcy1_reg;
            cpsy2_reg <= cpsy1_reg;
            srcp2_reg <= srcp1_reg;
            crcp2_reg <= crcp1_reg;
            crsy2_reg <= crsy1_reg;
            crcy2_reg <= crcy1_reg;
            srsy2_reg <= srsy1_reg;
            srcy2_reg <= srcy1_reg;

            srspcy3_reg <= srsp2_reg * cy2_reg;
            srspsy3_reg <= srsp2_reg * sy2_reg;
            crspcy3_reg <= crsp2_reg * cy2_reg;
            crspsy3_reg <= crsp2_reg * sy2_reg;
            cpcy3_reg   <= cpcy2_reg;
            cpsy3_reg   <= cpsy2_reg;
            srcp3_reg   <= srcp2_reg;
            crcp3_reg   <= crcp2_reg;
            crsy3_reg   <= crsy2_reg;
            crcy3_reg   <= crcy2_reg;
            srsy3_reg   <= srsy2_reg;
            srcy3_reg   <= srcy2_reg;
            sp3_reg     <= sp2_reg;

            for (int k = 0; k < e2b_pkg::NUM_COMP; k++)
            begin
                sum_reg[k]  <= sum_next[k];
                comp_reg[k] <= e2b_pkg::emit(sum_reg[k]);
            end
        end
    end

    assign out_valid = valid_reg[4];
    assign comp      = comp_reg;

endmodule
`default_nettype wire

// ===== sv/euler_to_basis_vectors.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Turns an orientation given as pitch, yaw and roll (signed, 1/256 degree)
// into the forward, right and up basis vectors, nine signed Q2.14 components
// rounded to nearest and clamped to plus or minus one. Any 18-bit angle is
// accepted and taken modulo one turn. The block takes one item every clock
// cycle while no result is held back at the output. Each item passes through
// angle reduction, the CORDIC rotations, rounding and quadrant fold-back,
// and the product and summation pipeline. The whole pipeline moves
// together; when a result is held back at the output the input stops taking
// items in the same cycle, and nothing is lost or repeated. The block keeps
// no state between items.
module euler_to_basis_vectors
#(
    parameter int TRIG_STAGES = e2b_pkg::TRIG_STAGES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pitch_angle [17:0], yaw_angle [35:18], roll_angle [53:36], zero [55:54]
    input  wire logic [55:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // forward_x [15:0], forward_y [31:16], forward_z [47:32],
    // right_x [63:48], right_y [79:64], right_z [95:80],
    // up_x [111:96], up_y [127:112], up_z [143:128]
    output logic [143:0]      m_axis_tdata
);

    logic en;

    // The pipeline advances whenever the output register is empty or is
    // being emptied in this cycle.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic            red_valid [3];
    e2b_pkg::angle_t red_angle [3];
    logic            trig_valid [3];
    e2b_pkg::trig_t  trig [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        e2b_angle_reduce u_reduce
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_axis_tvalid),
            .angle     ($signed(s_axis_tdata[a*e2b_pkg::ANGLE_W +: e2b_pkg::ANGLE_W])),
            .out_valid (red_valid[a]),
            .out_angle (red_angle[a])
        );

        e2b_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (red_valid[a]),
            .in_angle  (red_angle[a]),
            .out_valid (trig_valid[a]),
            .out_trig  (trig[a])
        );
    end

    logic                       basis_valid;
    logic [e2b_pkg::COMP_W-1:0] comp [e2b_pkg::NUM_COMP];

    e2b_basis u_basis
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trig_valid[0] && trig_valid[1] && trig_valid[2]),
        .pitch     (trig[0]),
        .yaw       (trig[1]),
        .roll      (trig[2]),
        .out_valid (basis_valid),
        .comp      (comp)
    );

    assign m_axis_tvalid = basis_valid;

    always_comb
    begin
        for (int k = 0; k < e2b_pkg::NUM_COMP; k++)
            m_axis_tdata[k*e2b_pkg::COMP_W +: e2b_pkg::COMP_W] = comp[k];
    end

    // The three angle lanes run in lock step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (trig_valid[0] == trig_valid[1]) && (trig_valid[1] == trig_valid[2]))
        else $error("angle lanes out of step");

    // A result held at the output stops the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // Components forward_z and right_y stay within plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[47:32]) <= 16'sd16384)
                       && ($signed(m_axis_tdata[47:32]) >= -16'sd16384)
                       && ($signed(m_axis_tdata[79:64]) <= 16'sd16384)
                       && ($signed(m_axis_tdata[79:64]) >= -16'sd16384))
        else $error("component outside range");

endmodule
`default_nettype wire

// ===== test/euler_to_basis_vectors_tb.sv =====
`timescale 1ns / 1ps
module euler_to_basis_vectors_tb;

    // Angle units and output format of the block.
    localparam int        DEG_FRAC   = 8;
    localparam int        OUT_FRAC   = 14;
    localparam int        ROT_STAGES = 16;
    localparam longint    TURN       = 360 << DEG_FRAC;
    localparam longint    QUARTER    = 90 << DEG_FRAC;
    localparam longint    EIGHTH     = 45 << DEG_FRAC;
    localparam logic [63:0] PI_QTR_Q62 = 64'h3243F6A8885A308D;
    localparam longint    CORDIC_K   = 64'h26DD3B6A;
    localparam int        RANDOM_ITEMS = 1000;
    // Pipeline depth is TRIG_STAGES + 10; allow a margin on top.
    localparam int        DRAIN_CYCLES = 60;

    typedef struct {
        logic [17:0]  pitch;
        logic [17:0]  yaw;
        logic [17:0]  roll;
        logic         typed;
        logic [143:0] basis;
    } orient_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    orient_item_t orientations[$];
    logic [143:0] pending_bases[$];
    int           next_item = 0;
    int           accepted = 0;
    int           mismatches = 0;
    bit           stimulus_ready = 1'b0;

    always #1 clk = ~clk;

    euler_to_basis_vectors uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // atan(2^-i) in Q.40, from the odd power series summed in Q.62.
    function automatic longint arctan_step(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        if (i == 0)
            return longint'((PI_QTR_Q62 + (64'd1 << 21)) >> 22);
        acc = '0;
        for (int k = 0; k < 32; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh <= 62)
            begin
                term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return longint'((acc + (64'd1 << 21)) >> 22);
    endfunction

    // Sine and cosine in Q.30 of an 18-bit angle, via quadrant fold and CORDIC.
    function automatic void angle_sin_cos(input logic [17:0] raw,
                                          output longint sn, output longint cs);
        longint m, quad, rem, z, x, y, dx, dy, s, c;
        logic   neg;
        logic [63:0] pi40;
        pi40 = (PI_QTR_Q62 + (64'd1 << 19)) >> 20;
        m = longint'($signed(raw)) % TURN;
        if (m < 0)
            m += TURN;
        quad = (m + EIGHTH) / QUARTER;
        rem  = m - quad * QUARTER;
        neg  = rem < 0;
        if (neg)
            rem = -rem;
        z = longint'((64'(rem) * pi40 + 64'((180 << DEG_FRAC) / 2)) / 64'(180 << DEG_FRAC));
        x = CORDIC_K * 1024;
        y = 0;
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (neg)
            s = -s;
        case (quad & 3)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // Round a Q.60 sum to Q2.14 and clamp to plus or minus one.
    function automatic logic [15:0] round_component(input longint v60);
        longint v;
        v = (v60 + (longint'(1) << (59 - OUT_FRAC))) >>> (60 - OUT_FRAC);
        if (v > (longint'(1) << OUT_FRAC))
            v = longint'(1) << OUT_FRAC;
        if (v < -(longint'(1) << OUT_FRAC))
            v = -(longint'(1) << OUT_FRAC);
        return v[15:0];
    endfunction

    function automatic logic [143:0] basis_vectors(input logic [17:0] pitch,
                                                   input logic [17:0] yaw,
                                                   input logic [17:0] roll);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        angle_sin_cos(pitch, sp, cp);
        angle_sin_cos(yaw, sy, cy);
        angle_sin_cos(roll, sr, cr);
        srsp = q30_product(sr, sp);
        crsp = q30_product(cr, sp);
        return {round_component(cr * cp),
                round_component(crsp * sy - sr * cy),
                round_component(crsp * cy + sr * sy),
                round_component(-(sr * cp)),
                round_component(-(srsp * sy) - cr * cy),
                round_component(-(srsp * cy) + cr * sy),
                round_component(-sp * (longint'(1) << 30)),
                round_component(cp * sy),
                round_component(cp * cy)};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic add_item(input int pitch, input int yaw, input int roll,
                            input logic typed, input logic [143:0] basis);
        orient_item_t it;
        it.pitch = pitch[17:0];
        it.yaw   = yaw[17:0];
        it.roll  = roll[17:0];
        it.typed = typed;
        it.basis = basis;
        orientations.push_back(it);
    endtask

    // Random angle: half the time within one turn, sometimes any 18-bit pattern,
    // sometimes right beside a 45 degree fold boundary.
    function automatic int random_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 184319) - 92160;
        else if (sel < 8)
            return $urandom_range(0, 262143);
        else
            return ($urandom_range(0, 16) - 8) * 11520 + $urandom_range(0, 4) - 2;
    endfunction

    // Directed table: the zero orientation has an obvious answer, the rest
    // are the field extremes, whole turns and quadrant edges.
    initial
    begin
        int angles[16];
        angles = '{0, 1, -1, 131071, -131072, 92159, -92160, 92160, 23040, -23040,
                   11520, 11519, 46080, 69120, 256, -256};
        add_item(0, 0, 0, 1'b1,
                 {16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                  16'sd0, 16'sd0, 16'sd16384});
        foreach (angles[i])
            add_item(angles[i], angles[(i + 5) % 16], angles[(i + 11) % 16], 1'b0, '0);
        add_item(131071, 131071, 131071, 1'b0, '0);
        add_item(-131072, -131072, -131072, 1'b0, '0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_item(random_angle(), random_angle(), random_angle(), 1'b0, '0);
        stimulus_ready = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idling phase: sender idles lightly then heavily, then nobody idles.
    function automatic int sender_idle_pct();
        if (accepted < orientations.size() / 3)
            return 10;
        else if (accepted < 2 * orientations.size() / 3)
            return 79;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted < orientations.size() / 3)
            return 79;
        else if (accepted < 2 * orientations.size() / 3)
            return 10;
        return 0;
    endfunction

    // Sender: an item is taken when valid and ready were both high at the edge.
    always @(posedge clk)
    begin
        if (rst_n && stimulus_ready)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                orient_item_t it;
                it = orientations[next_item - 1];
                pending_bases.push_back(it.typed ? it.basis
                                                 : basis_vectors(it.pitch, it.yaw, it.roll));
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (next_item < orientations.size()
                    && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    s_axis_tdata  <= {2'b00, orientations[next_item].roll,
                                      orientations[next_item].yaw,
                                      orientations[next_item].pitch};
                    s_axis_tvalid <= 1'b1;
                    next_item++;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: compare each result with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_bases.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    logic [143:0] want;
                    want = pending_bases.pop_front();
                    for (int c = 0; c < 9; c++)
                        if (m_axis_tdata[16 * c +: 16] !== want[16 * c +: 16])
                            report_mismatch($sformatf("component %0d got %0d expected %0d",
                                                      c,
                                                      $signed(m_axis_tdata[16 * c +: 16]),
                                                      $signed(want[16 * c +: 16])));
                end
            end
            m_axis_tready <= $urandom_range(0, 99) >= receiver_idle_pct();
        end
    end

    // Normal end: all items taken, all results back, then let the pipe drain.
    initial
    begin
        wait (stimulus_ready);
        wait (accepted == orientations.size() && pending_bases.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_bases.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
